FILE: sv/expiring_batch_edf_consumer_macros.svh
// Assertion macros used by the checker file of the expiring batch consumer
`ifndef EXPIRING_BATCH_EDF_CONSUMER_MACROS_SVH
`define EXPIRING_BATCH_EDF_CONSUMER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EBEDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define EBEDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ebedf_pkg.sv
// Shared widths, field positions and cell control types of the expiring batch consumer
`default_nettype none

package ebedf_pkg;

	localparam int COUNT_W = 16;
	localparam int LIFE_W = 16;
	localparam int DAY_W = 32;
	localparam int EXP_W = DAY_W + 1;
	localparam int TOTAL_W = 32;
	localparam int DEFAULT_STORE_DEPTH = 16;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	// result field positions in m_tdata
	localparam int M_CONSUMED_BIT = 0;
	localparam int M_TOTAL_LSB = 1;
	localparam int M_EMPTY_BIT = M_TOTAL_LSB + TOTAL_W;
	localparam int M_DROP_BIT = M_EMPTY_BIT + 1;
	localparam int M_USED_W = M_DROP_BIT + 1;

	typedef struct packed {
		logic pop;
		logic ins;
		logic dec;
	} entry_ctl_t;

	typedef struct packed {
		logic pop;
		logic push;
	} slot_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ebedf_entry_cell.sv
// One cell of the expiry-sorted batch chain: expiry, slot id, units left
`default_nettype none

module ebedf_entry_cell #(
	parameter int SLOT_W = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ebedf_pkg::entry_ctl_t        ctl,
	input  wire logic [ebedf_pkg::EXP_W-1:0]  new_expiry,
	input  wire logic [SLOT_W-1:0]            new_slot,
	input  wire logic [ebedf_pkg::COUNT_W-1:0] new_remaining,
	input  wire logic                         prev_valid,
	input  wire logic                         prev_gt,
	input  wire logic [ebedf_pkg::EXP_W-1:0]  prev_expiry,
	input  wire logic [SLOT_W-1:0]            prev_slot,
	input  wire logic [ebedf_pkg::COUNT_W-1:0] prev_remaining,
	input  wire logic                         next_valid,
	input  wire logic [ebedf_pkg::EXP_W-1:0]  next_expiry,
	input  wire logic [SLOT_W-1:0]            next_slot,
	input  wire logic [ebedf_pkg::COUNT_W-1:0] next_remaining,
	output logic                              valid,
	output logic                              gt,
	output logic [ebedf_pkg::EXP_W-1:0]       expiry,
	output logic [SLOT_W-1:0]                 slot,
	output logic [ebedf_pkg::COUNT_W-1:0]     remaining
);

	logic                          valid_q;
	logic [ebedf_pkg::EXP_W-1:0]   expiry_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [ebedf_pkg::COUNT_W-1:0] remaining_q;

	// empty cells sort after everything; slot ids are unique so keys never tie
	assign gt = !valid_q || ({expiry_q, slot_q} > {new_expiry, new_slot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (ctl.ins && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			expiry_q <= next_expiry;
			slot_q <= next_slot;
			remaining_q <= next_remaining;
		end else if (ctl.ins && gt) begin
			if (prev_gt) begin
				expiry_q <= prev_expiry;
				slot_q <= prev_slot;
				remaining_q <= prev_remaining;
			end else begin
				expiry_q <= new_expiry;
				slot_q <= new_slot;
				remaining_q <= new_remaining;
			end
		end else if (ctl.dec) begin
			remaining_q <= remaining_q - ebedf_pkg::COUNT_W'(1);
		end
	end

	assign valid = valid_q;
	assign expiry = expiry_q;
	assign slot = slot_q;
	assign remaining = remaining_q;

endmodule

`default_nettype wire

FILE: sv/ebedf_slot_cell.sv
// One cell of the sorted free-slot chain; the head is the lowest free slot
`default_nettype none

module ebedf_slot_cell #(
	parameter int SLOT_W = 4,
	parameter int INDEX = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ebedf_pkg::slot_ctl_t  ctl,
	input  wire logic [SLOT_W-1:0]     new_id,
	input  wire logic                  prev_valid,
	input  wire logic                  prev_gt,
	input  wire logic [SLOT_W-1:0]     prev_id,
	input  wire logic                  next_valid,
	input  wire logic [SLOT_W-1:0]     next_id,
	output logic                       valid,
	output logic                       gt,
	output logic [SLOT_W-1:0]          id
);

	logic              valid_q;
	logic [SLOT_W-1:0] id_q;

	assign gt = !valid_q || (id_q > new_id);

	// after reset every slot is free, in ascending order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b1;
			id_q <= SLOT_W'(INDEX);
		end else if (ctl.pop) begin
			valid_q <= next_valid;
			id_q <= next_id;
		end else if (ctl.push && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
			id_q <= prev_gt ? prev_id : new_id;
		end
	end

	assign valid = valid_q;
	assign id = id_q;

endmodule

`default_nettype wire

FILE: sv/expiring_batch_edf_consumer.sv
// A tick is accepted in idle; the purge state then pops each stored batch that has
// expired, one per cycle, and inserts the new batch if the store has room; the eat
// state then takes one unit from the head once the output register is free.
// Result sits in an output register; the next tick is taken while it waits.
// Reset (arst_n low, asynchronous): store empty, all slots free, day one,
// running total zero; no clearing pass is needed.
`default_nettype none

module expiring_batch_edf_consumer #(
	parameter int STORE_DEPTH = ebedf_pkg::DEFAULT_STORE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [15:0] batch_count, [31:16] shelf_life
	input  wire logic [ebedf_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] consumed, [32:1] total_consumed, [33] store_empty, [34] insert_dropped,
	// [39:35] zero
	output logic [ebedf_pkg::M_TDATA_W-1:0]       m_tdata
);

	localparam int SLOT_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int EXP_W = ebedf_pkg::EXP_W;
	localparam int COUNT_W = ebedf_pkg::COUNT_W;
	localparam int DAY_W = ebedf_pkg::DAY_W;
	localparam int TOTAL_W = ebedf_pkg::TOTAL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PURGE = 2'd1;
	localparam logic [1:0] ST_EAT = 2'd2;

	logic [1:0]         state_q;
	logic [DAY_W-1:0]   day_q;
	logic [TOTAL_W-1:0] total_q;
	logic [EXP_W-1:0]   expiry_q;
	logic [COUNT_W-1:0] count_q;
	logic               ins_q;
	logic               drop_q;
	logic               m_tvalid_q;
	logic [ebedf_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic                e_valid [STORE_DEPTH];
	logic                e_gt [STORE_DEPTH];
	logic [EXP_W-1:0]    e_exp [STORE_DEPTH];
	logic [SLOT_W-1:0]   e_slot [STORE_DEPTH];
	logic [COUNT_W-1:0]  e_rem [STORE_DEPTH];
	logic                f_valid [STORE_DEPTH];
	logic                f_gt [STORE_DEPTH];
	logic [SLOT_W-1:0]   f_id [STORE_DEPTH];

	ebedf_pkg::entry_ctl_t e_ctl;
	ebedf_pkg::slot_ctl_t  f_ctl;

	logic s_fire;
	logic out_free;
	logic head_expired;
	logic eat_fire;
	logic head_last;
	logic [TOTAL_W-1:0] total_next;
	logic empty_next;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign head_expired = e_valid[0] && (e_exp[0] <= {1'b0, day_q});
	assign eat_fire = (state_q == ST_EAT) && out_free;
	assign head_last = (e_rem[0] == COUNT_W'(1));
	assign total_next = e_valid[0] ? total_q + TOTAL_W'(1) : total_q;
	assign empty_next = (e_valid[0] && head_last) ? !e_valid[1] : !e_valid[0];

	// chain commands: purge and emptied heads pop, freeing their slot
	always_comb begin
		e_ctl = '0;
		f_ctl = '0;
		unique case (state_q)
			ST_PURGE: begin
				if (head_expired) begin
					e_ctl.pop = 1'b1;
					f_ctl.push = 1'b1;
				end else if (ins_q && !e_valid[STORE_DEPTH-1]) begin
					e_ctl.ins = 1'b1;
					f_ctl.pop = 1'b1;
				end
			end
			ST_EAT: begin
				if (out_free && e_valid[0]) begin
					if (head_last) begin
						e_ctl.pop = 1'b1;
						f_ctl.push = 1'b1;
					end else begin
						e_ctl.dec = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	genvar i;
	generate
		for (i = 0; i < STORE_DEPTH; i++) begin : g_cell
			ebedf_pkg::entry_ctl_t cell_ctl;
			logic                  pv_valid;
			logic                  pv_gt;
			logic [EXP_W-1:0]      pv_exp;
			logic [SLOT_W-1:0]     pv_slot;
			logic [COUNT_W-1:0]    pv_rem;
			logic                  nx_valid;
			logic [EXP_W-1:0]      nx_exp;
			logic [SLOT_W-1:0]     nx_slot;
			logic [COUNT_W-1:0]    nx_rem;
			logic                  fpv_valid;
			logic                  fpv_gt;
			logic [SLOT_W-1:0]     fpv_id;
			logic                  fnx_valid;
			logic [SLOT_W-1:0]     fnx_id;

			// only the head is decremented
			assign cell_ctl.pop = e_ctl.pop;
			assign cell_ctl.ins = e_ctl.ins;
			assign cell_ctl.dec = (i == 0) ? e_ctl.dec : 1'b0;

			if (i == 0) begin : g_first
				assign pv_valid = 1'b0;
				assign pv_gt = 1'b0;
				assign pv_exp = '0;
				assign pv_slot = '0;
				assign pv_rem = '0;
				assign fpv_valid = 1'b0;
				assign fpv_gt = 1'b0;
				assign fpv_id = '0;
			end else begin : g_mid
				assign pv_valid = e_valid[i-1];
				assign pv_gt = e_gt[i-1];
				assign pv_exp = e_exp[i-1];
				assign pv_slot = e_slot[i-1];
				assign pv_rem = e_rem[i-1];
				assign fpv_valid = f_valid[i-1];
				assign fpv_gt = f_gt[i-1];
				assign fpv_id = f_id[i-1];
			end

			if (i == STORE_DEPTH - 1) begin : g_last
				assign nx_valid = 1'b0;
				assign nx_exp = '0;
				assign nx_slot = '0;
				assign nx_rem = '0;
				assign fnx_valid = 1'b0;
				assign fnx_id = '0;
			end else begin : g_inner
				assign nx_valid = e_valid[i+1];
				assign nx_exp = e_exp[i+1];
				assign nx_slot = e_slot[i+1];
				assign nx_rem = e_rem[i+1];
				assign fnx_valid = f_valid[i+1];
				assign fnx_id = f_id[i+1];
			end

			ebedf_entry_cell #(
				.SLOT_W(SLOT_W)
			) u_entry (
				.clk            (clk),
				.arst_n         (arst_n),
				.ctl            (cell_ctl),
				.new_expiry     (expiry_q),
				.new_slot       (f_id[0]),
				.new_remaining  (count_q),
				.prev_valid     (pv_valid),
				.prev_gt        (pv_gt),
				.prev_expiry    (pv_exp),
				.prev_slot      (pv_slot),
				.prev_remaining (pv_rem),
				.next_valid     (nx_valid),
				.next_expiry    (nx_exp),
				.next_slot      (nx_slot),
				.next_remaining (nx_rem),
				.valid          (e_valid[i]),
				.gt             (e_gt[i]),
				.expiry         (e_exp[i]),
				.slot           (e_slot[i]),
				.remaining      (e_rem[i])
			);

			ebedf_slot_cell #(
				.SLOT_W(SLOT_W),
				.INDEX (i)
			) u_slot (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (f_ctl),
				.new_id     (e_slot[0]),
				.prev_valid (fpv_valid),
				.prev_gt    (fpv_gt),
				.prev_id    (fpv_id),
				.next_valid (fnx_valid),
				.next_id    (fnx_id),
				.valid      (f_valid[i]),
				.gt         (f_gt[i]),
				.id         (f_id[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			day_q <= DAY_W'(1);
			total_q <= '0;
			ins_q <= 1'b0;
			drop_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (eat_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						// a zero-life batch is already expired and never stored
						ins_q <= (s_tdata[15:0] != '0) && (s_tdata[31:16] != '0);
						state_q <= ST_PURGE;
					end
				end
				ST_PURGE: begin
					if (!head_expired) begin
						drop_q <= ins_q && e_valid[STORE_DEPTH-1];
						state_q <= ST_EAT;
					end
				end
				ST_EAT: begin
					if (out_free) begin
						total_q <= total_next;
						if (day_q != '1) begin
							day_q <= day_q + DAY_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			count_q <= s_tdata[15:0];
			expiry_q <= {1'b0, day_q} + EXP_W'(s_tdata[31:16]);
		end
		if (eat_fire) begin
			m_tdata_q <= ebedf_pkg::M_TDATA_W'({drop_q, empty_next, total_next, e_valid[0]});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

FILE: sv/ebedf_checker.sv
// Port-level checks of the expiring batch consumer, bound to the top level
`default_nettype none

`include "expiring_batch_edf_consumer_macros.svh"

module ebedf_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [ebedf_pkg::M_TDATA_W-1:0]  m_tdata
);

	logic s_fire;
	logic idle_result;
	logic drop_result;
	logic stalled;

	assign s_fire = s_tvalid && s_tready;
	assign idle_result = m_tvalid && !m_tdata[ebedf_pkg::M_CONSUMED_BIT];
	assign drop_result = m_tvalid && m_tdata[ebedf_pkg::M_DROP_BIT];
	assign stalled = m_tvalid && !m_tready;

	// one tick in flight: a request closes the input until its result is made
	`EBEDF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_fire, !s_tready && !$rose(m_tvalid),
		"request accepted while a tick is still in work")

	// nothing eaten means nothing was live, so the store must read empty
	`EBEDF_ASSERT_NOW(a_idle_means_empty, clk, arst_n, idle_result,
		m_tdata[ebedf_pkg::M_EMPTY_BIT], "no unit consumed but store not empty")

	// a drop needs a full store, which always feeds a unit and stays nonempty
	`EBEDF_ASSERT_NOW(a_drop_means_full, clk, arst_n, drop_result,
		m_tdata[ebedf_pkg::M_CONSUMED_BIT] && !m_tdata[ebedf_pkg::M_EMPTY_BIT],
		"insert dropped without a full store")

	`EBEDF_ASSERT_NEXT(a_result_holds, clk, arst_n, stalled, m_tvalid && $stable(m_tdata),
		"stalled result changed")

endmodule

bind expiring_batch_edf_consumer ebedf_checker u_ebedf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
